// ----- hdl/vdm_pkg.sv -----
// Package for the vector distance block: widths, job record and back-end states.
// Used by every module of the block; depends on nothing.
package vdm_pkg;

    localparam int MAX_DIMS = 1024;
    localparam int DIM_W    = $clog2(MAX_DIMS + 1);
    localparam int COORD_W  = 16;
    localparam int MAG_W    = 16;
    localparam int TERM_W   = 32;
    localparam int SUM_W    = 42;
    localparam int ROOT_W   = 44;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic MODE_EUCLID    = 1'b0;
    localparam logic MODE_MANHATTAN = 1'b1;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             mode;
    } vdm_job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ROOT,
        BK_HOLD
    } vdm_state_t;

endpackage

// ----- hdl/vdm_front.sv -----
// Front end: takes coordinate pairs, forms the per-pair term and accumulates it.
// Holds the metric mode register and hands finished sums on as jobs; uses vdm_pkg.
module vdm_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [15:0]            coord_a,
    input  logic signed [15:0]            coord_b,
    input  logic                          last_coord,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data,
    output logic                          job_push,
    output vdm_pkg::vdm_job_t             job,
    input  logic                          job_full
);
    import vdm_pkg::*;

    logic                mode_reg;
    logic [DIM_W-1:0]    dim_cnt_reg, dim_cnt_next;
    logic                s1_valid_reg, s1_valid_next;
    logic [TERM_W-1:0]   s1_term_reg;
    logic                s1_last_reg;
    logic                s1_mode_reg;
    logic                s1_sat_reg;
    logic [SUM_W-1:0]    sum_reg, sum_next;

    logic                take;
    logic                s1_load;
    logic                s2_go;
    logic [COORD_W:0]    diff;
    logic [MAG_W-1:0]    mag;
    logic [TERM_W-1:0]   sq;
    logic [TERM_W-1:0]   term;
    logic                sat_now;
    logic [SUM_W:0]      sum_add;
    logic [SUM_W-1:0]    sum_new;

    assign cfg_ready = 1'b1;

    assign s2_go   = s1_valid_reg && (!s1_last_reg || !job_full);
    assign full    = s1_valid_reg && !s2_go;
    assign take    = push && !full;
    assign s1_load = !s1_valid_reg || s2_go;

    assign diff    = {coord_a[COORD_W-1], coord_a} - {coord_b[COORD_W-1], coord_b};
    assign mag     = diff[COORD_W] ? MAG_W'(~diff + 1'b1) : MAG_W'(diff);
    assign sq      = mag * mag;
    assign term    = (mode_reg == MODE_MANHATTAN) ? TERM_W'(mag) : sq;
    assign sat_now = (dim_cnt_reg >= DIM_W'(MAX_DIMS));

    assign sum_add = {1'b0, sum_reg} + (SUM_W + 1)'(s1_term_reg);
    assign sum_new = (s1_sat_reg || sum_add[SUM_W]) ? SUM_MAX : sum_add[SUM_W-1:0];

    assign job_push = s2_go && s1_last_reg;
    assign job.sum  = sum_new;
    assign job.mode = s1_mode_reg;

    always_comb
    begin
        dim_cnt_next = dim_cnt_reg;
        if (take)
        begin
            if (last_coord)
                dim_cnt_next = '0;
            else if (!sat_now)
                dim_cnt_next = dim_cnt_reg + 1'b1;
        end
        s1_valid_next = s1_load ? take : s1_valid_reg;
        sum_next = sum_reg;
        if (s2_go)
            sum_next = s1_last_reg ? '0 : sum_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_EUCLID;
            dim_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            sum_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                mode_reg <= cfg_data;
            dim_cnt_reg  <= dim_cnt_next;
            s1_valid_reg <= s1_valid_next;
            sum_reg      <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && take)
        begin
            s1_term_reg <= term;
            s1_last_reg <= last_coord;
            s1_mode_reg <= mode_reg;
            s1_sat_reg  <= sat_now;
        end
    end

    a_dim_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dim_cnt_reg <= DIM_W'(MAX_DIMS))
        else $error("dimension count beyond limit");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(job_push && job_full))
        else $error("job pushed into a full queue");

endmodule

// ----- hdl/vdm_queue.sv -----
// Two-entry queue of finished sums between the front and back ends.
// Uses the job record of vdm_pkg.
module vdm_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  vdm_pkg::vdm_job_t  wr_data,
    output logic               q_full,
    input  logic               rd_en,
    output vdm_pkg::vdm_job_t  rd_data,
    output logic               q_empty
);
    import vdm_pkg::*;

    vdm_job_t     entry_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         do_wr;
    logic         do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count out of range");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

// ----- hdl/vdm_back.sv -----
// Back end: takes jobs from the queue, runs the digit-by-digit square root for
// euclidean jobs and holds the result register; uses vdm_pkg.
module vdm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  vdm_pkg::vdm_job_t   q_data,
    output logic                q_pop,
    output logic                empty,
    input  logic                pop,
    output logic [41:0]         distance
);
    import vdm_pkg::*;

    vdm_state_t          state_reg, state_next;
    logic [SUM_W-1:0]    x_reg, x_next;
    logic [ROOT_W-1:0]   res_reg, res_next;
    logic [ROOT_W-1:0]   bit_reg, bit_next;
    logic                out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]    distance_reg;
    logic                out_load;
    logic [ROOT_W-1:0]   trial;
    logic                ge;

    assign trial    = res_reg + bit_reg;
    assign ge       = (ROOT_W'(x_reg) >= trial);
    assign empty    = !out_valid_reg;
    assign distance = distance_reg;

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        res_next       = res_reg;
        bit_next       = bit_reg;
        q_pop          = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !pop;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    x_next   = q_data.sum;
                    bit_next = ROOT_W'(1) << (SUM_W);
                    if (q_data.mode == MODE_MANHATTAN)
                    begin
                        res_next   = ROOT_W'(q_data.sum);
                        state_next = BK_HOLD;
                    end
                    else
                    begin
                        res_next   = '0;
                        state_next = BK_ROOT;
                    end
                end
            end
            BK_ROOT:
            begin
                if (ge)
                begin
                    x_next   = x_reg - SUM_W'(trial);
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_next == '0)
                    state_next = BK_HOLD;
            end
            BK_HOLD:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        if (out_load)
            distance_reg <= res_reg[SUM_W-1:0];
    end

    a_bit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_ROOT) |-> $onehot(bit_reg))
        else $error("root step bit is not one-hot");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> $stable(distance_reg) && out_valid_reg)
        else $error("waiting result changed");

endmodule

// ----- hdl/vector_distance_metric.sv -----
// Top level of the vector distance block: front end, job queue and back end.
// Depends on vdm_pkg, vdm_front, vdm_queue and vdm_back.
//
// Usage: coordinate pairs (signed Q8.8) are pushed one per item with push/full;
// last_coord marks the final pair of a vector. One distance per vector leaves
// through empty/pop and is shown on distance while empty is low.
// The cfg channel (cfg_valid/cfg_ready, always ready) writes metric_mode:
// 0 gives the euclidean distance, the floor square root of the summed squared
// differences; 1 gives the sum of absolute differences. Both are Q34.8.
// Throughput: one item per cycle into the two-stage accumulator while full
// is low. The back end handles one vector at a time: a manhattan result goes
// straight to the hold state, a euclidean one first runs the 22 iterations
// of the square-root unit. A two-entry job queue lets the next vector stream
// in during the root. When pop stays low the result register holds, the
// queue fills and full rises; no item or result is lost. Reset clears the
// sum, the dimension count, the queue and the result valid flag and sets
// metric_mode to 0.
module vector_distance_metric (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic signed [15:0]  coord_a,
    input  logic signed [15:0]  coord_b,
    input  logic                last_coord,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,
    output logic                empty,
    input  logic                pop,
    output logic [41:0]         distance
);
    import vdm_pkg::*;

    logic      job_push;
    vdm_job_t  job;
    logic      job_full;
    logic      q_pop;
    vdm_job_t  q_data;
    logic      q_empty;

    vdm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .coord_a    (coord_a),
        .coord_b    (coord_b),
        .last_coord (last_coord),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .job_push   (job_push),
        .job        (job),
        .job_full   (job_full)
    );

    vdm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job),
        .q_full  (job_full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .q_empty (q_empty)
    );

    vdm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .distance (distance)
    );

endmodule

// ----- dv/vdm_checker.sv -----
// Checker for the vector distance block: watches the item, config and result channels.
// Predicts each distance from the accepted coordinate pairs and compares it with the result.
// Depends on vdm_pkg for widths, limits and mode codes.
module vdm_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    input  logic                               full,
    input  logic signed [vdm_pkg::COORD_W-1:0] coord_a,
    input  logic signed [vdm_pkg::COORD_W-1:0] coord_b,
    input  logic                               last_coord,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic                               cfg_data,
    input  logic                               empty,
    input  logic                               pop,
    input  logic [vdm_pkg::SUM_W-1:0]          distance,
    output int                                 pending,
    output int                                 fail_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import vdm_pkg::*;

    logic [SUM_W-1:0] acc;
    int unsigned      dims;
    logic             mode;
    int               errs;
    logic [SUM_W-1:0] expected_dist[$];

    function automatic logic [SUM_W-1:0] int_sqrt(logic [SUM_W-1:0] x);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int i = 21; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= 64'(x))
                root = trial;
        end
        return root[SUM_W-1:0];
    endfunction

    function automatic void take_pair(logic signed [COORD_W-1:0] a,
                                      logic signed [COORD_W-1:0] b, logic l);
        logic signed [COORD_W:0] d;
        logic [COORD_W:0]        mag;
        logic [SUM_W-1:0]        m42;
        logic [SUM_W-1:0]        term;
        d    = a - b;
        mag  = (d < 0) ? -d : d;
        m42  = SUM_W'(mag);
        term = (mode == MODE_EUCLID) ? m42 * m42 : m42;
        if (dims >= MAX_DIMS) begin
            acc = SUM_MAX;
        end else begin
            dims++;
            if (acc > SUM_MAX - term)
                acc = SUM_MAX;
            else
                acc = acc + term;
        end
        if (l) begin
            expected_dist.push_back((mode == MODE_EUCLID) ? int_sqrt(acc) : acc);
            acc  = '0;
            dims = 0;
        end
    endfunction

    function automatic void check_result(logic [SUM_W-1:0] got);
        logic [SUM_W-1:0] want;
        if (expected_dist.size() == 0) begin
            errs++;
            if (errs <= 10)
                $display("unexpected distance item: got %0d", got);
        end else begin
            want = expected_dist.pop_front();
            if (got !== want) begin
                errs++;
                if (errs <= 10)
                    $display("distance mismatch: expected %0d got %0d", want, got);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc  = '0;
            dims = 0;
            mode = MODE_EUCLID;
            errs = 0;
            expected_dist.delete();
            pending    <= 0;
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready)
                mode = cfg_data;
            if (pop && !empty)
                check_result(distance);
            if (push && !full)
                take_pair(coord_a, coord_b, last_coord);
            pending    <= expected_dist.size();
            fail_count <= errs;
        end
    end

endmodule

// ----- dv/vector_distance_metric_tb.sv -----
// Testbench top for vector_distance_metric: clock, reset, item and config stimulus, pop pattern.
// Instantiates the block and vdm_checker, which predicts and compares; this module gives the verdict.
// Depends on vdm_pkg, vector_distance_metric and vdm_checker.
module vector_distance_metric_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vdm_pkg::*;

    localparam int SETTLE = 40;
    localparam int LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 600;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      push;
    logic                      full;
    logic signed [COORD_W-1:0] coord_a;
    logic signed [COORD_W-1:0] coord_b;
    logic                      last_coord;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic                      cfg_data;
    logic                      empty;
    logic                      pop = 1'b0;
    logic [SUM_W-1:0]          distance;

    int pending;
    int fail_count;
    int cycles = 0;
    int burst_left = 0;
    int items_sent = 0;
    int rx_style = 0;
    int rx_phase = 0;
    int rx_hold = 0;

    vector_distance_metric dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .coord_a    (coord_a),
        .coord_b    (coord_b),
        .last_coord (last_coord),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .empty      (empty),
        .pop        (pop),
        .distance   (distance)
    );

    vdm_checker distance_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .coord_a    (coord_a),
        .coord_b    (coord_b),
        .last_coord (last_coord),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .empty      (empty),
        .pop        (pop),
        .distance   (distance),
        .pending    (pending),
        .fail_count (fail_count)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("vector_distance_metric_tb NOT OK");
            $finish;
        end
    end

    // The receiver switches between steady popping, random popping, sparse popping and
    // long stalls.
    always @(negedge clk)
    begin
        if (rx_phase == 0) begin
            rx_style = $urandom_range(0, 3);
            rx_phase = $urandom_range(16, 96);
        end else begin
            rx_phase--;
        end
        case (rx_style)
            0: pop <= 1'b1;
            1: pop <= $urandom_range(0, 1);
            2: pop <= ($urandom_range(0, 3) == 0);
            default:
            begin
                if (rx_hold == 0) begin
                    pop <= 1'b1;
                    rx_hold = $urandom_range(5, 40);
                end else begin
                    pop <= 1'b0;
                    rx_hold--;
                end
            end
        endcase
    end

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return COORD_W'($signed($urandom_range(0, 31)) - 16);
            3: return '0;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    task automatic send_pair(input logic signed [COORD_W-1:0] a,
                             input logic signed [COORD_W-1:0] b, input logic l);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
            burst_left = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 16);
            repeat (gap)
            begin
                @(negedge clk);
                push <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        push       <= 1'b1;
        coord_a    <= a;
        coord_b    <= b;
        last_coord <= l;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
    endtask

    // Waits until every predicted distance has been popped and the back end has settled.
    task automatic drain_and_settle();
        @(negedge clk);
        push <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_vector(input int len, input logic signed [COORD_W-1:0] a,
                               input logic signed [COORD_W-1:0] b, input logic use_random);
        for (int k = 0; k < len; k++) begin
            if (use_random)
                send_pair(rand_coord(), rand_coord(), k == len - 1);
            else
                send_pair(a, b, k == len - 1);
        end
    endtask

    initial
    begin
        int base;
        int len;
        int switch_at;
        int vec_idx;
        int r;

        rst_n      = 1'b0;
        push       = 1'b0;
        coord_a    = '0;
        coord_b    = '0;
        last_coord = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, starting in the reset mode (euclidean).
        send_pair(16'sh7fff, 16'sh8000, 1'b1);
        send_pair(16'sh8000, 16'sh7fff, 1'b1);
        send_pair(16'sh0000, 16'sh0000, 1'b1);
        send_pair(16'sh0001, 16'sh0000, 1'b1);
        send_vector(3, 16'sh7fff, 16'sh8000, 1'b0);
        send_pair(16'shffff, 16'shffff, 1'b1);
        // The mode changes in the middle of a vector.
        send_pair(16'sd100, -16'sd100, 1'b0);
        drain_and_settle();
        write_mode(MODE_MANHATTAN);
        send_pair(16'sd5, 16'sd3, 1'b1);
        send_pair(16'sh7fff, 16'sh8000, 1'b1);
        send_pair(16'sh0000, 16'sh0000, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 1'b1);
        send_pair(-16'sd5, 16'sd7, 1'b1);
        send_vector(4, 16'sh8000, 16'sh7fff, 1'b0);
        send_pair(16'sd3, 16'sd0, 1'b0);
        drain_and_settle();
        write_mode(MODE_EUCLID);
        send_pair(16'sd4, 16'sd0, 1'b1);

        // Random vectors, mostly short, with occasional mode changes.
        base    = items_sent;
        vec_idx = 0;
        while (items_sent - base < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                drain_and_settle();
                write_mode(logic'($urandom_range(0, 1)));
            end
            if (vec_idx == 25)
                drain_and_settle();
            r = $urandom_range(0, 19);
            if (r < 15)
                len = $urandom_range(1, 6);
            else if (r < 19)
                len = $urandom_range(7, 32);
            else
                len = $urandom_range(33, 90);
            switch_at = (len > 1 && $urandom_range(0, 14) == 0) ? $urandom_range(1, len - 1)
                                                                : -1;
            for (int k = 0; k < len; k++) begin
                if (k == switch_at) begin
                    drain_and_settle();
                    write_mode(logic'($urandom_range(0, 1)));
                end
                send_pair(rand_coord(), rand_coord(), k == len - 1);
            end
            vec_idx++;
        end

        drain_and_settle();
        if (fail_count == 0 && pending == 0)
            $display("vector_distance_metric_tb OK");
        else
            $display("vector_distance_metric_tb NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/vdm_pkg.sv
hdl/vdm_front.sv
hdl/vdm_queue.sv
hdl/vdm_back.sv
hdl/vector_distance_metric.sv
dv/vdm_checker.sv
dv/vector_distance_metric_tb.sv
